// ===== design/hcs_pkg.sv =====
// Shared types and constants for the Hamiltonian cycle search block.
`default_nettype none

package hcs_pkg;

  localparam int MAX_NODES = 8;
  localparam int NODES_DEF = 8;
  localparam int NODE_W    = 3;
  localparam int ADJ_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = MAX_NODES * NODE_W;

  localparam logic [MAX_NODES-1:0][ADJ_W-1:0] ROW_RESET = {
    8'd33, 8'd18, 8'd144, 8'd104, 8'd20, 8'd10, 8'd69, 8'd130
  };

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INIT,
    OP_STEP,
    OP_LOAD_NONE,
    OP_LOAD_PATH
  } uop_t;

  typedef struct packed {
    logic start_bad;
    logic stop;
    logic empty;
  } hcs_flags_t;

endpackage

`default_nettype wire

// ===== design/hamiltonian_cycle_search.sv =====
// Top level of the Hamiltonian cycle search: adjacency registers and the sequencer.
//
// The graph is held in eight adjacency-row registers written through cfg_we,
// cfg_index and cfg_data; bit j of row i marks an edge from node i to node j.
// The user must write rows only while no search is in flight (not enforced).
// Each transfer on the input channel carries a start node. The block runs a
// depth-first backtracking search and returns one result transfer: a found
// flag and the first cycle in lexicographic order, node k in bits 3k+2..3k.
// The microcoded sequencer makes one push or pop of the path per cycle. The
// result is offered once the search stops and the result registers are loaded;
// a search that visits all 13700 partial paths of eight nodes makes about
// 27400 pushes and pops. One item is in flight at a time and the input is
// ready again in the cycle after its result is transferred.
// While the receiver stalls, the result stays on the output unchanged and no
// new item is accepted. Reset loads the default graph, clears the search
// state and leaves the block ready for an input.
`default_nettype none

module hamiltonian_cycle_search
  import hcs_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADJ_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [NODE_W-1:0]    start_node,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      cycle_found,
  output logic [OUT_W-1:0]          cycle_nodes
);

  logic [MAX_NODES-1:0][ADJ_W-1:0] adj;
  hcs_flags_t                      flags;
  uop_t                            op;

  always_ff @(posedge clk) begin
    if (rst) begin
      adj <= ROW_RESET;
    end else if (cfg_we) begin
      adj[cfg_index] <= cfg_data;
    end
  end

  hcs_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .op        (op)
  );

  hcs_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .start_node  (start_node),
    .adj         (adj),
    .flags       (flags),
    .cycle_found (cycle_found),
    .cycle_nodes (cycle_nodes)
  );

endmodule

`default_nettype wire

// ===== design/hcs_useq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
`default_nettype none

module hcs_useq
  import hcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire hcs_flags_t flags,
  output uop_t            op
);

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_ACC,
    C_START_BAD,
    C_STOP,
    C_EMPTY,
    C_OUT_ACC
  } cond_t;

  typedef struct packed {
    uop_t        op;
    cond_t       cond;
    logic        take;
    logic        show;
    logic [2:0]  jt;
    logic [2:0]  jf;
  } uword_t;

  localparam logic [2:0] A_WAIT  = 3'd0;
  localparam logic [2:0] A_CHECK = 3'd1;
  localparam logic [2:0] A_SRCH  = 3'd2;
  localparam logic [2:0] A_SEL   = 3'd3;
  localparam logic [2:0] A_FAIL  = 3'd4;
  localparam logic [2:0] A_FOUND = 3'd5;
  localparam logic [2:0] A_SEND  = 3'd6;

  function automatic uword_t rom(input logic [2:0] a);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, take: 1'b0, show: 1'b0, jt: A_WAIT, jf: A_WAIT};
    unique case (a)
      A_WAIT:  w = '{op: OP_INIT, cond: C_IN_ACC, take: 1'b1, show: 1'b0,
                     jt: A_CHECK, jf: A_WAIT};
      A_CHECK: w = '{op: OP_NOP, cond: C_START_BAD, take: 1'b0, show: 1'b0,
                     jt: A_FAIL, jf: A_SRCH};
      A_SRCH:  w = '{op: OP_STEP, cond: C_STOP, take: 1'b0, show: 1'b0,
                     jt: A_SEL, jf: A_SRCH};
      A_SEL:   w = '{op: OP_NOP, cond: C_EMPTY, take: 1'b0, show: 1'b0,
                     jt: A_FAIL, jf: A_FOUND};
      A_FAIL:  w = '{op: OP_LOAD_NONE, cond: C_ALWAYS, take: 1'b0, show: 1'b0,
                     jt: A_SEND, jf: A_SEND};
      A_FOUND: w = '{op: OP_LOAD_PATH, cond: C_ALWAYS, take: 1'b0, show: 1'b0,
                     jt: A_SEND, jf: A_SEND};
      A_SEND:  w = '{op: OP_NOP, cond: C_OUT_ACC, take: 1'b0, show: 1'b1,
                     jt: A_WAIT, jf: A_SEND};
      default: w = '{op: OP_NOP, cond: C_ALWAYS, take: 1'b0, show: 1'b0,
                     jt: A_WAIT, jf: A_WAIT};
    endcase
    return w;
  endfunction

  logic [2:0] upc;
  logic [2:0] upc_next;
  uword_t     word;
  logic       in_acc;
  logic       out_acc;
  logic       hit;

  assign word      = rom(upc);
  assign in_ready  = word.take;
  assign out_valid = word.show;
  assign in_acc    = in_valid & word.take;
  assign out_acc   = out_ready & word.show;

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:    hit = 1'b1;
      C_IN_ACC:    hit = in_acc;
      C_START_BAD: hit = flags.start_bad;
      C_STOP:      hit = flags.stop;
      C_EMPTY:     hit = flags.empty;
      C_OUT_ACC:   hit = out_acc;
      default:     hit = 1'b0;
    endcase
    upc_next = hit ? word.jt : word.jf;
    op = ((word.op == OP_INIT) && !in_acc) ? OP_NOP : word.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/hcs_datapath.sv =====
// Search datapath: path and candidate stacks, visited set and result registers.
`default_nettype none

module hcs_datapath
  import hcs_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire uop_t                             op,
  input  wire logic [NODE_W-1:0]                start_node,
  input  wire logic [MAX_NODES-1:0][ADJ_W-1:0]  adj,
  output hcs_flags_t                            flags,
  output logic                                  cycle_found,
  output logic [OUT_W-1:0]                      cycle_nodes
);

  localparam int IW = $clog2(NODES);
  localparam int DW = $clog2(NODES + 1);

  function automatic logic [NODES-1:0] bit_of(input logic [NODE_W-1:0] n);
    logic [NODES-1:0] r;
    for (int j = 0; j < NODES; j++) begin
      r[j] = (NODE_W'(j) == n);
    end
    return r;
  endfunction

  logic [NODE_W-1:0] pstack [NODES];
  logic [DW-1:0]     ncand  [NODES];
  logic [NODES-1:0]  visited;
  logic [DW-1:0]     depth;
  logic [NODE_W-1:0] start;

  logic [DW-1:0]     dm1;
  logic [IW-1:0]     d_idx;
  logic [IW-1:0]     p_idx;
  logic [NODE_W-1:0] u;
  logic [ADJ_W-1:0]  row_full;
  logic [NODES-1:0]  row;
  logic [DW-1:0]     c;
  logic [NODES-1:0]  cand;
  logic [NODE_W-1:0] k;
  logic              full;
  logic              close;
  logic              empty;
  logic              adv;
  logic [OUT_W-1:0]  packed_path;

  always_comb begin
    dm1      = depth - DW'(1);
    d_idx    = dm1[IW-1:0];
    p_idx    = depth[IW-1:0];
    u        = pstack[d_idx];
    row_full = adj[u];
    row      = row_full[NODES-1:0];
    c        = ncand[d_idx];
    empty    = (depth == '0);
    full     = (depth == DW'(NODES));
    close    = full & row_full[start];
    for (int j = 0; j < NODES; j++) begin
      cand[j] = row[j] & ~visited[j] & (DW'(j) >= c);
    end
    k = '0;
    for (int j = NODES - 1; j >= 0; j--) begin
      if (cand[j]) begin
        k = NODE_W'(j);
      end
    end
    adv = |cand;
    flags.start_bad = ({1'b0, start} >= (NODE_W + 1)'(NODES));
    flags.stop      = empty | close;
    flags.empty     = empty;
  end

  for (genvar g = 0; g < MAX_NODES; g++) begin : g_pack
    if (g < NODES) begin : g_used
      assign packed_path[g*NODE_W +: NODE_W] = pstack[g];
    end else begin : g_zero
      assign packed_path[g*NODE_W +: NODE_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      depth   <= '0;
    end else begin
      unique case (op)
        OP_INIT: begin
          visited <= bit_of(start_node);
          depth   <= DW'(1);
        end
        OP_STEP: begin
          if (!empty && !close) begin
            if (!full && adv) begin
              visited <= visited | bit_of(k);
              depth   <= depth + DW'(1);
            end else begin
              visited <= visited & ~bit_of(u);
              depth   <= dm1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_INIT: begin
        start     <= start_node;
        pstack[0] <= start_node;
        ncand[0]  <= '0;
      end
      OP_STEP: begin
        if (!empty && !full) begin
          if (adv) begin
            ncand[d_idx]  <= DW'(k) + DW'(1);
            pstack[p_idx] <= k;
            ncand[p_idx]  <= '0;
          end else begin
            ncand[d_idx] <= DW'(NODES);
          end
        end
      end
      OP_LOAD_NONE: begin
        cycle_found <= 1'b0;
        cycle_nodes <= '0;
      end
      OP_LOAD_PATH: begin
        cycle_found <= 1'b1;
        cycle_nodes <= packed_path;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
